// ===== sv/lds_pkg.sv =====
package lds_pkg;

	localparam int WORD_BITS = 12;
	localparam int SLOT_BITS = 4 * WORD_BITS;
	localparam int BIT_CNT_W = $clog2(SLOT_BITS + 1);
	localparam int IDLE_CNT_W = 4;
	localparam int GAP_W = 3;
	localparam int ADDR_W = 3;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [WORD_BITS-1:0] CMD_WORD = 12'h3AA;
	localparam logic [GAP_W-1:0] GAP_MAX = 3'd4;
	localparam logic [GAP_W-1:0] GAP_RESET = 3'd4;

	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_ONE = 2'd1;
	localparam logic [1:0] KIND_IDLE = 2'd2;

	localparam logic REG_LATCH_GAP = 1'b0;
	localparam logic REG_FRAME_GAP = 1'b1;

	typedef struct packed {
		logic [WORD_BITS-1:0] blue_level;
		logic [WORD_BITS-1:0] green_level;
		logic [WORD_BITS-1:0] red_level;
		logic last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [1:0] slot_kind;
		logic last_slot;
	} out_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] blue_level;
		logic [WORD_BITS-1:0] green_level;
		logic [WORD_BITS-1:0] red_level;
		logic [IDLE_CNT_W-1:0] idle_cnt;
	} task_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/lds_front.sv =====
module lds_front (
	input  logic in_valid,
	output logic in_stall,
	input  lds_pkg::in_item_t in_item,
	input  logic [lds_pkg::GAP_W-1:0] latch_gap,
	input  logic [lds_pkg::GAP_W-1:0] frame_gap,
	input  lds_pkg::q_stat_t q_stat,
	output logic push,
	output lds_pkg::task_t task_item
);
	import lds_pkg::*;

	function automatic logic [GAP_W-1:0] sat_gap(input logic [GAP_W-1:0] v);
		return (v > GAP_MAX) ? GAP_MAX : v;
	endfunction

	logic [GAP_W-1:0] latch_sat;
	logic [GAP_W-1:0] frame_sat;

	assign in_stall = q_stat.full;
	assign push = in_valid && !q_stat.full;

	always_comb begin
		latch_sat = sat_gap(latch_gap);
		frame_sat = in_item.last_pixel ? sat_gap(frame_gap) : '0;
		task_item.blue_level = in_item.blue_level;
		task_item.green_level = in_item.green_level;
		task_item.red_level = in_item.red_level;
		task_item.idle_cnt = IDLE_CNT_W'(latch_sat) + IDLE_CNT_W'(frame_sat);
	end

endmodule

// ===== sv/lds_queue.sv =====
module lds_queue #(
	parameter int DEPTH = lds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lds_pkg::task_t wdata,
	input  logic pop,
	output lds_pkg::task_t rdata,
	output lds_pkg::q_stat_t q_stat
);
	import lds_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	task_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lds_back.sv =====
module lds_back (
	input  logic clk,
	input  logic arst_n,
	input  lds_pkg::q_stat_t q_stat,
	input  lds_pkg::task_t task_item,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output lds_pkg::out_item_t out_item
);
	import lds_pkg::*;

	logic busy_q;
	logic [SLOT_BITS-1:0] shift_q;
	logic [BIT_CNT_W-1:0] bits_left_q;
	logic [IDLE_CNT_W-1:0] idle_left_q;
	logic out_valid_q;
	out_item_t out_q;

	logic adv;
	logic step;
	logic has_bits;
	logic last_now;
	logic [1:0] kind_now;

	assign adv = !out_valid_q || !out_stall;
	assign step = busy_q && adv;
	assign has_bits = (bits_left_q != '0);
	assign last_now = has_bits ?
		(bits_left_q == BIT_CNT_W'(1) && idle_left_q == '0) :
		(idle_left_q == IDLE_CNT_W'(1));
	assign kind_now = !has_bits ? KIND_IDLE : (shift_q[SLOT_BITS-1] ? KIND_ONE : KIND_ZERO);
	assign pop = !q_stat.empty && (!busy_q || (step && last_now));

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (step && last_now) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= {CMD_WORD, task_item.blue_level, task_item.green_level,
				task_item.red_level};
			bits_left_q <= BIT_CNT_W'(SLOT_BITS);
			idle_left_q <= task_item.idle_cnt;
		end else if (step) begin
			if (has_bits) begin
				shift_q <= {shift_q[SLOT_BITS-2:0], 1'b0};
				bits_left_q <= bits_left_q - 1'b1;
			end else begin
				idle_left_q <= idle_left_q - 1'b1;
			end
		end
		if (step) begin
			out_q.slot_kind <= kind_now;
			out_q.last_slot <= last_now;
		end
	end

endmodule

// ===== sv/led_driver_single_wire_serializer_top.sv =====
// Path: an accepted pixel is written to the queue, popped into the serializer
// shift register, and its slots are registered at the output. Throughput: one
// slot per cycle while out_stall is low; a pixel takes 48 bit slots plus 0 to 8
// idle slots (latch gap, plus frame gap on the last pixel), all from the single
// slot serializer in the back end. Reset: arst_n clears the queue, serializer
// and output valid; both gap registers reset to 4.
module led_driver_single_wire_serializer_top #(
	parameter int QUEUE_DEPTH = lds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lds_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output lds_pkg::out_item_t out_item,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [lds_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lds_pkg::*;

	logic [GAP_W-1:0] latch_gap_q;
	logic [GAP_W-1:0] frame_gap_q;
	logic cfg_wr;
	logic reg_sel;
	logic push;
	logic pop;
	task_t push_task;
	task_t head_task;
	q_stat_t q_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_comb begin
		unique case (reg_sel)
			REG_LATCH_GAP: prdata = {{(32 - GAP_W){1'b0}}, latch_gap_q};
			REG_FRAME_GAP: prdata = {{(32 - GAP_W){1'b0}}, frame_gap_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_gap_q <= GAP_RESET;
			frame_gap_q <= GAP_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_LATCH_GAP) begin
				latch_gap_q <= pwdata[GAP_W-1:0];
			end else begin
				frame_gap_q <= pwdata[GAP_W-1:0];
			end
		end
	end

	lds_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item (in_item),
		.latch_gap (latch_gap_q),
		.frame_gap (frame_gap_q),
		.q_stat (q_stat),
		.push (push),
		.task_item (push_task)
	);

	lds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.wdata (push_task),
		.pop (pop),
		.rdata (head_task),
		.q_stat (q_stat)
	);

	lds_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.task_item (head_task),
		.pop (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item (out_item)
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.slot_kind == KIND_ZERO || out_item.slot_kind == KIND_ONE
			|| out_item.slot_kind == KIND_IDLE))
		else $error("illegal slot kind");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_sel == REG_LATCH_GAP) |=> latch_gap_q == $past(pwdata[GAP_W-1:0]))
		else $error("latch gap write lost");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lds_pkg::*;

	localparam int DRAIN_PAD = 8;
	localparam int IDLE_PCT = 14;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	logic [GAP_W-1:0] latch_gap;
	logic [GAP_W-1:0] frame_gap;
	out_item_t pending_slots[$];
	out_item_t want_slot;
	bit no_idle;
	int n_errors;
	int n_pixels;
	int n_frames;
	int n_slots;
	int n_settings;

	led_driver_single_wire_serializer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [GAP_W-1:0] clamp_gap(input logic [GAP_W-1:0] g);
		return (g > GAP_MAX) ? GAP_MAX : g;
	endfunction

	// command word, then blue, green, red MSB first, then latch and frame idle slots
	function automatic void encode_pixel(input in_item_t px);
		logic [WORD_BITS-1:0] words [4];
		out_item_t s;
		int n_idle;
		int total;
		int k;
		words[0] = CMD_WORD;
		words[1] = px.blue_level;
		words[2] = px.green_level;
		words[3] = px.red_level;
		n_idle = clamp_gap(latch_gap);
		if (px.last_pixel)
			n_idle += clamp_gap(frame_gap);
		total = 4 * WORD_BITS + n_idle;
		k = 0;
		for (int w = 0; w < 4; w++) begin
			for (int b = WORD_BITS - 1; b >= 0; b--) begin
				s.slot_kind = words[w][b] ? KIND_ONE : KIND_ZERO;
				s.last_slot = (k == total - 1);
				pending_slots.push_back(s);
				k++;
			end
		end
		for (int i = 0; i < n_idle; i++) begin
			s.slot_kind = KIND_IDLE;
			s.last_slot = (k == total - 1);
			pending_slots.push_back(s);
			k++;
		end
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_level();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return 12'h800;
			3: return 12'h001;
			default: return WORD_BITS'($urandom_range(4095));
		endcase
	endfunction

	function automatic in_item_t random_pixel();
		in_item_t px;
		px.blue_level = pick_level();
		px.green_level = pick_level();
		px.red_level = pick_level();
		px.last_pixel = 1'($urandom_range(1));
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send_pixel(input in_item_t px);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			in_item <= random_pixel();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= px;
		do @(posedge clk); while (in_stall);
		encode_pixel(px);
		n_pixels++;
		if (px.last_pixel)
			n_frames++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_slots.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_idx == REG_LATCH_GAP)
			latch_gap = data[GAP_W-1:0];
		else
			frame_gap = data[GAP_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_gaps(input int lg, input int fg);
		logic [31:0] junk;
		wait_drain();
		junk = $urandom_range(1) ? ($urandom() & ~32'h7) : 32'h0;
		apb_write(REG_LATCH_GAP, junk | 32'(lg));
		junk = $urandom_range(1) ? ($urandom() & ~32'h7) : 32'h0;
		apb_write(REG_FRAME_GAP, junk | 32'(fg));
		n_settings++;
	endtask

	task automatic test_reset_gaps();
		send_pixel('{12'h000, 12'h000, 12'h000, 1'b0});
		send_pixel('{12'hFFF, 12'hFFF, 12'hFFF, 1'b1});
		send_pixel('{12'h800, 12'h001, 12'h800, 1'b0});
		send_pixel('{12'h555, 12'hAAA, 12'h555, 1'b1});
		send_pixel('{12'h001, 12'h800, 12'hFFF, 1'b1});
	endtask

	// zero gaps, saturated gaps, and mixes
	task automatic test_gap_settings();
		int lgs [7] = '{0, 7, 0, 4, 5, 1, 2};
		int fgs [7] = '{0, 7, 4, 0, 6, 3, 1};
		in_item_t px;
		for (int i = 0; i < 7; i++) begin
			set_gaps(lgs[i], fgs[i]);
			px = random_pixel();
			px.last_pixel = 1'b0;
			send_pixel(px);
			px = random_pixel();
			px.last_pixel = 1'b1;
			send_pixel(px);
		end
	endtask

	// sender holds off mid-frame until the output has fully drained
	task automatic test_drain_pause();
		in_item_t px;
		set_gaps(3, 2);
		for (int i = 0; i < 4; i++) begin
			px = random_pixel();
			px.last_pixel = (i == 3);
			send_pixel(px);
			if (i == 1)
				wait_drain();
		end
	endtask

	task automatic test_random_frames(input int n_target);
		int sent;
		int phase;
		int phase_len;
		int frame_len;
		int lg;
		int fg;
		in_item_t px;
		sent = 0;
		phase = 0;
		while (sent < n_target) begin
			lg = ($urandom_range(3) == 0) ? 7 * $urandom_range(1) : $urandom_range(7);
			fg = ($urandom_range(3) == 0) ? 7 * $urandom_range(1) : $urandom_range(7);
			set_gaps(lg, fg);
			no_idle = (phase == 2);
			phase_len = $urandom_range(50, 30);
			while (phase_len > 0 && sent < n_target) begin
				frame_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(6, 1);
				for (int k = 0; k < frame_len; k++) begin
					px = random_pixel();
					px.last_pixel = (k == frame_len - 1);
					send_pixel(px);
					sent++;
					phase_len--;
				end
			end
			no_idle = 1'b0;
			phase++;
		end
	endtask

	always @(negedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_slots++;
			if (pending_slots.size() == 0) begin
				report_mismatch($sformatf("unexpected slot kind=%0d last=%0b",
					out_item.slot_kind, out_item.last_slot));
			end else begin
				want_slot = pending_slots.pop_front();
				if (out_item.slot_kind !== want_slot.slot_kind)
					report_mismatch($sformatf("slot %0d kind got %0d want %0d",
						n_slots, out_item.slot_kind, want_slot.slot_kind));
				if (out_item.last_slot !== want_slot.last_slot)
					report_mismatch($sformatf("slot %0d last_slot got %0b want %0b",
						n_slots, out_item.last_slot, want_slot.last_slot));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d slots still pending", pending_slots.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_idle = 1'b0;
		latch_gap = GAP_RESET;
		frame_gap = GAP_RESET;
		n_errors = 0;
		n_pixels = 0;
		n_frames = 0;
		n_slots = 0;
		n_settings = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_gaps();
		test_gap_settings();
		test_drain_pause();
		test_random_frames(327);

		wait_drain();
		$display("sent %0d pixels in %0d frames under %0d gap settings plus reset values",
			n_pixels, n_frames, n_settings);
		$display("checked %0d slots, %0d mismatches", n_slots, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== led_driver_single_wire_serializer_top.f =====
sv/lds_pkg.sv
sv/lds_front.sv
sv/lds_queue.sv
sv/lds_back.sv
sv/led_driver_single_wire_serializer_top.sv
tb/tb.sv
